@@ src/gsak_pkg.sv @@
package gsak_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SQ_W       = 2 * CHAN_W;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned SCALE_W    = 14;
  localparam int unsigned RAD_W      = 32;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned ROOT_STEPS = ROOT_W;

  localparam logic [SCALE_W-1:0] KEY_SCALE  = 14'd10000;
  localparam logic [ROOT_W-1:0]  KEY_OFFSET = 16'd8925;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // one slot of the square root chain
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  radicand;
    pixel_t            pix;
  } sqrt_lane_t;

endpackage

@@ src/green_screen_alpha_key_unit.sv @@
// green-screen soft keyer: each rgb pixel leaves with its color untouched and an
// alpha byte that ramps from 0 near pure green (0,255,0) to 255 far from it,
// alpha = clamp(floor((isqrt(10000*s) - 8925) / 8), 0, 255) with
// s = r^2 + (255-g)^2 + b^2. one pixel is taken every clock while the sink keeps
// up; the pipe holds registers for squares, sum and scale, then a chain of
// square root cells that each settle one root bit, then the alpha ramp and
// output register. when the sink stalls, the whole pipe holds.
module green_screen_alpha_key_unit (
  input  logic        clk,
  input  logic        rst,
  // request in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  // request out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // red_out, green_out, blue_out, alpha_out from bit 0 up
);

  logic                 en;
  gsak_pkg::pixel_t     in_pix;
  gsak_pkg::sqrt_lane_t lane [gsak_pkg::ROOT_STEPS+1];

  logic [gsak_pkg::ROOT_W-1:0]   root;
  logic [gsak_pkg::ROOT_W-1:0]   excess;
  logic [gsak_pkg::CHAN_W-1:0]   alpha_next;
  gsak_pkg::pixel_t              out_pix;
  logic [gsak_pkg::CHAN_W-1:0]   out_alpha;

  // the whole pipe moves unless a finished request sits unclaimed
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign in_pix   = s_tdata;

  gsak_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_pix   (in_pix),
    .out_lane (lane[0])
  );

  // root bits settle msb first, two radicand bits per cell
  for (genvar i = 0; i < gsak_pkg::ROOT_STEPS; i++) begin : g_cell
    gsak_sqrt_cell #(
      .BIT_POS (gsak_pkg::RAD_W - 2 - 2 * i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_lane  (lane[i]),
      .out_lane (lane[i+1])
    );
  end

  // linear ramp, zero below the offset, saturate above 255
  assign root   = lane[gsak_pkg::ROOT_STEPS].root;
  assign excess = root - gsak_pkg::KEY_OFFSET;

  always_comb begin
    if (root < gsak_pkg::KEY_OFFSET) begin
      alpha_next = '0;
    end else if (|excess[gsak_pkg::ROOT_W-1:11]) begin
      alpha_next = '1;
    end else begin
      alpha_next = excess[10:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= lane[gsak_pkg::ROOT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix   <= lane[gsak_pkg::ROOT_STEPS].pix;
      out_alpha <= alpha_next;
    end
  end

  assign m_tdata = {out_alpha, out_pix};

`ifndef NO_ASSERTIONS
  // a pure green pixel is fully transparent
  a_green_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] == 8'd0 && m_tdata[15:8] == 8'd255 && m_tdata[23:16] == 8'd0)
      |-> m_tdata[31:24] == 8'd0)
    else $error("pure green pixel got nonzero alpha");

  // full red is far from green and must saturate
  a_red_opaque: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] == 8'd255) |-> m_tdata[31:24] == 8'd255)
    else $error("full red pixel not opaque");

  // an accepted request enters the front of the pipe
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> u_dist.sq_valid)
    else $error("accepted request lost at pipe entry");
`endif

endmodule

@@ src/gsak_dist.sv @@
module gsak_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  gsak_pkg::pixel_t    in_pix,
  output gsak_pkg::sqrt_lane_t out_lane
);

  // stage 1: squares
  logic                            sq_valid;
  gsak_pkg::pixel_t                sq_pix;
  logic [gsak_pkg::SQ_W-1:0]       sq_r;
  logic [gsak_pkg::SQ_W-1:0]       sq_g;
  logic [gsak_pkg::SQ_W-1:0]       sq_b;
  // stage 2: sum of squares
  logic                            sum_valid;
  gsak_pkg::pixel_t                sum_pix;
  logic [gsak_pkg::SUM_W-1:0]      sum;

  logic [gsak_pkg::CHAN_W-1:0]     dg;

  // 255 - g
  assign dg = ~in_pix.green;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid       <= 1'b0;
      sum_valid      <= 1'b0;
      out_lane.valid <= 1'b0;
    end else if (en) begin
      sq_valid       <= in_valid;
      sum_valid      <= sq_valid;
      out_lane.valid <= sum_valid;
    end
    if (en) begin
      sq_pix <= in_pix;
      sq_r   <= gsak_pkg::SQ_W'(in_pix.red) * gsak_pkg::SQ_W'(in_pix.red);
      sq_g   <= gsak_pkg::SQ_W'(dg) * gsak_pkg::SQ_W'(dg);
      sq_b   <= gsak_pkg::SQ_W'(in_pix.blue) * gsak_pkg::SQ_W'(in_pix.blue);

      sum_pix <= sq_pix;
      sum     <= gsak_pkg::SUM_W'(sq_r) + gsak_pkg::SUM_W'(sq_g)
               + gsak_pkg::SUM_W'(sq_b);

      out_lane.pix      <= sum_pix;
      out_lane.radicand <= gsak_pkg::RAD_W'(sum) * gsak_pkg::RAD_W'(gsak_pkg::KEY_SCALE);
      out_lane.rem      <= '0;
      out_lane.root     <= '0;
    end
  end

endmodule

@@ src/gsak_sqrt_cell.sv @@
module gsak_sqrt_cell #(
  parameter int unsigned BIT_POS = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  gsak_pkg::sqrt_lane_t in_lane,
  output gsak_pkg::sqrt_lane_t out_lane
);

  logic [gsak_pkg::REM_W+1:0]  rem_sh;
  logic [gsak_pkg::REM_W+1:0]  trial;
  gsak_pkg::sqrt_lane_t        lane_next;

  always_comb begin
    rem_sh    = {in_lane.rem, in_lane.radicand[BIT_POS+1:BIT_POS]};
    trial     = {2'b00, in_lane.root, 2'b01};
    lane_next = in_lane;
    if (rem_sh >= trial) begin
      lane_next.rem  = gsak_pkg::REM_W'(rem_sh - trial);
      lane_next.root = {in_lane.root[gsak_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      lane_next.rem  = rem_sh[gsak_pkg::REM_W-1:0];
      lane_next.root = {in_lane.root[gsak_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_lane.valid <= 1'b0;
    end else if (en) begin
      out_lane.valid <= lane_next.valid;
    end
    if (en) begin
      out_lane.rem      <= lane_next.rem;
      out_lane.root     <= lane_next.root;
      out_lane.radicand <= lane_next.radicand;
      out_lane.pix      <= lane_next.pix;
    end
  end

endmodule

@@ test/green_screen_alpha_key_unit_test.sv @@
`timescale 1ns / 100ps
module green_screen_alpha_key_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned REPORT_MAX   = 10;

  // keyer arithmetic: root of scaled squared distance, offset, divided by 8
  localparam int unsigned DIST_GAIN    = 10000;
  localparam int unsigned RAMP_START   = 8925;
  localparam int unsigned RAMP_SHIFT   = 3;
  localparam int unsigned ALPHA_FULL   = 255;
  localparam int unsigned CHAN_FULL    = 255;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // red_in [7:0], green_in [15:8], blue_in [23:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // red_out, green_out, blue_out, alpha_out from bit 0 up

  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold      = 1'b0;
  logic [31:0] keyed_pixels_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  string       field_names[4] = '{"red_out", "green_out", "blue_out", "alpha_out"};

  green_screen_alpha_key_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [gsak_pkg::CHAN_W-1:0] predict_alpha(gsak_pkg::pixel_t pix);
    int unsigned      red_d;
    int unsigned      green_d;
    int unsigned      blue_d;
    int unsigned      scaled;
    int unsigned      root;
    int unsigned      trial;
    int unsigned      ramp;
    int               bit_pos;
    red_d   = pix.red;
    green_d = CHAN_FULL - pix.green;
    blue_d  = pix.blue;
    scaled  = (red_d * red_d + green_d * green_d + blue_d * blue_d) * DIST_GAIN;
    // floor square root, one bit at a time from the top
    root = 0;
    for (bit_pos = 15; bit_pos >= 0; bit_pos--) begin
      trial = root | (32'd1 << bit_pos);
      if (longint'(trial) * longint'(trial) <= longint'(scaled))
        root = trial;
    end
    if (root < RAMP_START)
      return '0;
    ramp = (root - RAMP_START) >> RAMP_SHIFT;
    if (ramp > ALPHA_FULL)
      ramp = ALPHA_FULL;
    return ramp[gsak_pkg::CHAN_W-1:0];
  endfunction

  // mostly pixels near green so the alpha ramp is well covered
  function automatic gsak_pkg::pixel_t random_pixel();
    gsak_pkg::pixel_t pix;
    int unsigned      reach;
    int unsigned      mode;
    mode = $urandom_range(9);
    if (mode < 3) begin
      pix = 24'($urandom);
    end else begin
      reach = (mode < 7) ? 115 : 70;
      pix.red   = 8'($urandom_range(reach));
      pix.green = 8'(CHAN_FULL - $urandom_range(reach));
      pix.blue  = 8'($urandom_range(reach));
    end
    return pix;
  endfunction

  task automatic send_pixel(input gsak_pkg::pixel_t pix);
    logic [31:0] keyed_pix;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    keyed_pix      = {predict_alpha(pix), pix};
    keyed_pixels_q = {keyed_pixels_q, keyed_pix};
  endtask

  task automatic test_directed_corners();
    // hex blue, green, red
    logic [23:0] corners[] = '{
      24'h00FF00, 24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h0000FF, 24'hFF0000,
      24'h00FFFF, 24'hFFFF00, 24'h00FF59, 24'h07FF59, 24'h0AFF59, 24'h00FF64,
      24'h00FF6D, 24'h00FF6E, 24'h009100, 24'h009B00, 24'h64FF00, 24'h3CC33C,
      24'hAA55AA, 24'h55AA55, 24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE
    };
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    foreach (corners[i])
      send_pixel(corners[i]);
  endtask

  task automatic test_random_pixels(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned count);
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count)
      send_pixel(random_pixel());
  endtask

  // sink goes quiet while pixels keep coming, so the pipe fills and stalls its input
  task automatic test_sink_hold_off();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES)
          @(posedge clk);
        sink_hold <= 1'b0;
      end
      repeat (60)
        send_pixel(random_pixel());
    join
  endtask

  task automatic wait_for_drain();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (keyed_pixels_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    logic [31:0] expected_pix;
    if (!rst && m_tvalid && m_tready) begin
      if (keyed_pixels_q.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("%0t: result %h with nothing pending", $realtime, m_tdata);
        mismatch_count++;
      end else begin
        expected_pix = keyed_pixels_q.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (m_tdata[8*f +: 8] !== expected_pix[8*f +: 8]) begin
            if (mismatch_count < REPORT_MAX)
              $display("%0t: %s expected %0d got %0d (pixel %h)", $realtime, field_names[f],
                       expected_pix[8*f +: 8], m_tdata[8*f +: 8], expected_pix[23:0]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11)
      @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_pixels(0, 0, 340);
    test_random_pixels(87, 0, 320);
    test_random_pixels(0, 87, 320);
    test_random_pixels(21, 21, 300);
    test_sink_hold_off();
    wait_for_drain();
    if (mismatch_count == 0 && keyed_pixels_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
